@@ rtl/core/tri3_pkg.sv @@
`default_nettype none

package tri3_pkg;

  localparam int FIELD_BITS  = 16;
  localparam int NUM_FIELDS  = 9;
  localparam int S_DATA_BITS = FIELD_BITS * NUM_FIELDS;
  localparam int OUT_BITS    = 43;
  localparam int M_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  // The root is computed one bit wider than the result so that saturation can be seen.
  localparam int ROOT_BITS = OUT_BITS + 1;
  localparam int RAD_BITS  = 2 * ROOT_BITS;
  localparam int REM_BITS  = ROOT_BITS + 2;

  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [RAD_BITS-1:0]   rad_t;
  typedef logic [ROOT_BITS-1:0]  root_t;
  typedef logic [OUT_BITS-1:0]   area_t;

  // First field in the lowest bits.
  typedef struct packed {
    field_t c_z;
    field_t c_y;
    field_t c_x;
    field_t b_z;
    field_t b_y;
    field_t b_x;
    field_t a_z;
    field_t a_y;
    field_t a_x;
  } verts_t;

endpackage

`default_nettype wire

@@ rtl/core/tri3_cross.sv @@
`default_nettype none

module tri3_cross #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire tri3_pkg::verts_t           verts,
  output logic                            out_valid,
  output logic signed [2*COORD_BITS+2:0]  cx,
  output logic signed [2*COORD_BITS+2:0]  cy,
  output logic signed [2*COORD_BITS+2:0]  cz
);
  import tri3_pkg::*;

  localparam int C = COORD_BITS;
  localparam int D = C + 1;
  localparam int P = 2 * D;
  localparam int X = P + 1;

  // Low COORD_BITS bits of the field, sign-extended by one bit for the edge difference.
  function automatic logic signed [D-1:0] coord(field_t f);
    logic [C-1:0] low;
    low = C'(f);
    return D'(signed'(low));
  endfunction

  logic                v1, v2;
  logic signed [D-1:0] ux, uy, uz, vx, vy, vz;
  logic signed [P-1:0] p_uy_vz, p_vy_uz, p_vx_uz, p_ux_vz, p_ux_vy, p_vx_uy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux <= coord(verts.b_x) - coord(verts.a_x);
      uy <= coord(verts.b_y) - coord(verts.a_y);
      uz <= coord(verts.b_z) - coord(verts.a_z);
      vx <= coord(verts.c_x) - coord(verts.a_x);
      vy <= coord(verts.c_y) - coord(verts.a_y);
      vz <= coord(verts.c_z) - coord(verts.a_z);

      p_uy_vz <= P'(uy) * P'(vz);
      p_vy_uz <= P'(vy) * P'(uz);
      p_vx_uz <= P'(vx) * P'(uz);
      p_ux_vz <= P'(ux) * P'(vz);
      p_ux_vy <= P'(ux) * P'(vy);
      p_vx_uy <= P'(vx) * P'(uy);

      cx <= X'(p_uy_vz) - X'(p_vy_uz);
      cy <= X'(p_vx_uz) - X'(p_ux_vz);
      cz <= X'(p_ux_vy) - X'(p_vx_uy);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tri3_sumsq.sv @@
`default_nettype none

module tri3_sumsq #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic signed [2*COORD_BITS+2:0]    cx,
  input  wire logic signed [2*COORD_BITS+2:0]    cy,
  input  wire logic signed [2*COORD_BITS+2:0]    cz,
  output logic                                   out_valid,
  output tri3_pkg::rad_t                         rad
);
  import tri3_pkg::*;

  localparam int XW    = 2 * COORD_BITS + 3;
  localparam int MW    = XW - 1;
  localparam int H     = COORD_BITS + 1;
  localparam int PW    = 2 * H;
  localparam int SQ    = 2 * MW;
  localparam int SB    = SQ + 2;
  localparam int SHIFT = (FRAC_BITS == 0) ? 0 : 2 * FRAC_BITS - 2;
  localparam int NW    = SB + SHIFT;

  logic signed [XW-1:0] cin [3];
  logic [MW-1:0]        m   [3];
  logic [PW-1:0]        ll  [3];
  logic [PW-1:0]        hl  [3];
  logic [PW-1:0]        hh  [3];
  logic [SQ-1:0]        sq  [3];
  logic [SB-1:0]        s;
  logic [NW-1:0]        n_full;
  rad_t                 n_clip;
  logic                 va, vb, vc, vd;

  assign cin[0] = cx;
  assign cin[1] = cy;
  assign cin[2] = cz;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      vd        <= vc;
      out_valid <= vd;
    end
  end

  // Each square is split into halves so that no multiplier exceeds H by H bits.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m[i]  <= cin[i][XW-1] ? MW'(-cin[i]) : MW'(cin[i]);
        ll[i] <= PW'(m[i][H-1:0]) * PW'(m[i][H-1:0]);
        hl[i] <= PW'(m[i][MW-1:H]) * PW'(m[i][H-1:0]);
        hh[i] <= PW'(m[i][MW-1:H]) * PW'(m[i][MW-1:H]);
        sq[i] <= (SQ'(hh[i]) << (2 * H)) + (SQ'(hl[i]) << (H + 1)) + SQ'(ll[i]);
      end
      s   <= SB'(sq[0]) + SB'(sq[1]) + SB'(sq[2]);
      rad <= n_clip;
    end
  end

  assign n_full = NW'(s) << SHIFT;

  // A radicand beyond the root range is clamped; its root then saturates the result.
  if (NW > RAD_BITS) begin : g_clip
    assign n_clip = (|n_full[NW-1:RAD_BITS]) ? '1 : n_full[RAD_BITS-1:0];
  end else begin : g_fit
    assign n_clip = rad_t'(n_full);
  end

endmodule

`default_nettype wire

@@ rtl/core/tri3_isqrt.sv @@
`default_nettype none

module tri3_isqrt #(
  parameter int FRAC_BITS = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire tri3_pkg::rad_t  rad,
  output logic                 out_valid,
  output tri3_pkg::area_t      area
);
  import tri3_pkg::*;

  localparam int RB = ROOT_BITS;

  logic                rv  [RB];
  rad_t                rr  [RB];
  logic [REM_BITS-1:0] rem [RB];
  root_t               q   [RB];

  // One root bit per stage, restoring digit-by-digit method.
  for (genvar i = 0; i < RB; i++) begin : g_step
    rad_t                rad_in;
    logic [REM_BITS-1:0] rem_in;
    root_t               q_in;
    logic                v_in;
    logic [REM_BITS+1:0] acc;
    logic [REM_BITS+1:0] trial;
    logic                ge;

    if (i == 0) begin : g_first
      assign rad_in = rad;
      assign rem_in = '0;
      assign q_in   = '0;
      assign v_in   = in_valid;
    end else begin : g_next
      assign rad_in = rr[i-1];
      assign rem_in = rem[i-1];
      assign q_in   = q[i-1];
      assign v_in   = rv[i-1];
    end

    assign acc   = {rem_in, rad_in[RAD_BITS-1 -: 2]};
    assign trial = (REM_BITS + 2)'({q_in, 2'b01});
    assign ge    = (acc >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        rv[i] <= 1'b0;
      end else if (en) begin
        rv[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rr[i]  <= rad_in << 2;
        rem[i] <= ge ? REM_BITS'(acc - trial) : REM_BITS'(acc);
        q[i]   <= {q_in[ROOT_BITS-2:0], ge};
      end
    end
  end

  assign out_valid = rv[RB-1];

  // Without fraction bits the area is half the root; otherwise the root saturates.
  if (FRAC_BITS == 0) begin : g_half
    assign area = q[RB-1][ROOT_BITS-1:1];
  end else begin : g_sat
    assign area = q[RB-1][ROOT_BITS-1] ? '1 : q[RB-1][OUT_BITS-1:0];
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    rv[RB-1] |-> (rem[RB-1] <= REM_BITS'({q[RB-1], 1'b0})))
    else $error("square root remainder exceeds twice the root");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(rv[RB-1]) && $stable(q[RB-1]))
    else $error("last root stage changed while the pipeline was stalled");

endmodule

`default_nettype wire

@@ rtl/core/tri3_outq.sv @@
`default_nettype none

module tri3_outq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tri3_pkg::area_t  push_data,
  output logic                  space,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output tri3_pkg::area_t       out_data
);
  import tri3_pkg::*;

  area_t      slot0, slot1;
  logic       wp, rp;
  logic [1:0] count, count_next;
  logic       pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = (count != 2'd0);
  assign space     = (count != 2'd2);
  assign out_data  = rp ? slot1 : slot0;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !wp) begin
      slot0 <= push_data;
    end
    if (push && wp) begin
      slot1 <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != 2'd2) || pop)
    else $error("result queue written while full");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue count out of range");

endmodule

`default_nettype wire

@@ rtl/core/triangle_area_3d_top.sv @@
// Triangle area from three 3-D vertices, one item per clock while the receiver keeps up.
// Slave side (s_tvalid, s_tready, s_tdata) takes the nine vertex coordinates;
// master side (m_tvalid, m_tready, m_tdata) returns the area in unsigned fixed
// point with FRAC_BITS fraction bits, truncated, saturating at all ones.
// Coordinates are the low COORD_BITS bits of each field, sign-extended.
// The datapath is an 8-stage front end (edge vectors, products, cross product,
// magnitudes, split squares, sum, scaling) followed by a 44-stage square root
// that resolves one root bit per stage. Each result then passes through the
// result queue before it can be taken at the output.
// Throughput is one item per cycle while the receiver keeps up.
// A two-entry result queue sits at the output. When the receiver stalls the
// pipeline keeps moving until the queue fills; then the whole pipeline
// freezes and s_tready drops, and nothing is lost or repeated.
// Synchronous reset empties the pipeline and the queue; no state is kept
// between items.
`default_nettype none

module triangle_area_3d_top #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 16 bits each from bit 0 up
  input  wire logic [tri3_pkg::S_DATA_BITS-1:0] s_tdata,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // area_fixed in bits 42:0, zeros above
  output logic [tri3_pkg::M_DATA_BITS-1:0]      m_tdata
);
  import tri3_pkg::*;

  localparam int XW = 2 * COORD_BITS + 3;

  verts_t               verts;
  logic                 en;
  logic                 x_valid, r_valid, a_valid;
  logic signed [XW-1:0] cx, cy, cz;
  rad_t                 rad;
  area_t                area, q_area;

  assign verts    = verts_t'(s_tdata);
  assign s_tready = en;

  tri3_cross #(
    .COORD_BITS(COORD_BITS)
  ) u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .verts     (verts),
    .out_valid (x_valid),
    .cx        (cx),
    .cy        (cy),
    .cz        (cz)
  );

  tri3_sumsq #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_sumsq (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (x_valid),
    .cx        (cx),
    .cy        (cy),
    .cz        (cz),
    .out_valid (r_valid),
    .rad       (rad)
  );

  tri3_isqrt #(
    .FRAC_BITS(FRAC_BITS)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .rad       (rad),
    .out_valid (a_valid),
    .area      (area)
  );

  tri3_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (en & a_valid),
    .push_data (area),
    .space     (en),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (q_area)
  );

  assign m_tdata = {{(M_DATA_BITS - OUT_BITS){1'b0}}, q_area};

endmodule

`default_nettype wire
